[src/vfpt_pkg.sv]
// Shared types and constants for the video frame packet tracker.
// Used by video_frame_packet_tracker, vfpt_map and vfpt_ts; no dependencies.
package vfpt_pkg;

  localparam int MaxPacketsDef  = 128;
  localparam int LinesPerPacket = 4;

  localparam int FrameW  = 16;
  localparam int LineW   = 15;
  localparam int MsW     = 32;
  localparam int TimeW   = 64;
  localparam int IntvW   = 27;
  localparam int HeightW = 16;
  localparam int TmoW    = 16;
  localparam int CountW  = 8;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 64;
  // internal packet counts: up to 256 packets, expected count capped at 257
  localparam int CntW    = 9;
  localparam int MagW    = 16;
  localparam int ProdW   = MagW + IntvW;

  localparam logic [HeightW-1:0] UnknownSplit = 16'd250;
  localparam logic [FrameW-1:0]  HalfRange    = 16'd32768;

  localparam logic [TmoW-1:0]    TimeoutRst  = 16'd100;
  localparam logic [IntvW-1:0]   PalIntvRst  = 27'd19950125;
  localparam logic [IntvW-1:0]   NtscIntvRst = 27'd16715282;
  localparam logic [HeightW-1:0] PalHgtRst   = 16'd272;
  localparam logic [HeightW-1:0] NtscHgtRst  = 16'd240;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TIMEOUT   = 3'd0,
    REG_BASE_TIME = 3'd1,
    REG_PAL_INTV  = 3'd2,
    REG_NTSC_INTV = 3'd3,
    REG_PAL_HGT   = 3'd4,
    REG_NTSC_HGT  = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PKT_ACCEPTED     = 2'd0,
    PKT_DUPLICATE    = 2'd1,
    PKT_OUT_OF_RANGE = 2'd2
  } pkt_status_e;

  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_DELIVERED = 2'd1,
    EV_TIMED_OUT = 2'd2,
    EV_ABANDONED = 2'd3
  } frame_event_e;

  // per-request result fields carried down the pipe next to the timestamp
  typedef struct packed {
    pkt_status_e         status;
    frame_event_e        event_kind;
    logic [FrameW-1:0]   ev_frame;
    logic [HeightW-1:0]  height;
    logic                pal;
    logic [CountW-1:0]   rcv;
    logic [CountW-1:0]   expct;
  } res_t;

endpackage

[src/video_frame_packet_tracker.sv]
// Video frame packet tracker top level: input decode, frame state update and
// result pipeline. Depends on vfpt_pkg, vfpt_map and vfpt_ts.
//
// Takes one packet header per cycle; each result passes through tag memory read,
// state update, multiply and base add after its request is accepted, and
// the whole pipe holds only while the output register waits to be taken. The
// received map is a MAX_PACKETS-entry tag memory: a frame change bumps an epoch
// instead of clearing it, and a scrubber on the second read port retires stale
// tags, so no clearing pass is needed after reset.
module video_frame_packet_tracker #(
  parameter int MaxPackets = vfpt_pkg::MaxPacketsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [vfpt_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [vfpt_pkg::CfgW-1:0]       cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [vfpt_pkg::FrameW-1:0]     frame_number_i,
  input  logic [vfpt_pkg::LineW-1:0]      start_line_i,
  input  logic                            is_last_i,
  input  logic [vfpt_pkg::MsW-1:0]        arrival_ms_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      packet_status_o,
  output logic [1:0]                      frame_event_o,
  output logic [vfpt_pkg::FrameW-1:0]     event_frame_o,
  output logic [vfpt_pkg::TimeW-1:0]      ideal_time_ns_o,
  output logic [vfpt_pkg::HeightW-1:0]    height_lines_o,
  output logic                            is_pal_o,
  output logic [vfpt_pkg::CountW-1:0]     received_count_o,
  output logic [vfpt_pkg::CountW-1:0]     expected_count_o
);

  localparam int AddrW   = $clog2(MaxPackets);
  localparam int EpochW  = AddrW + 2;
  localparam int LineW   = vfpt_pkg::LineW;
  localparam int CntW    = vfpt_pkg::CntW;
  localparam int Lpp     = vfpt_pkg::LinesPerPacket;
  // line / Lpp as a reciprocal multiply, exact over the whole line range
  localparam int Shift   = LineW + $clog2(Lpp);
  localparam int Recip   = ((2 ** Shift) + Lpp - 1) / Lpp;
  localparam int IdxPW   = LineW + Shift + 1;
  localparam int ExpCap  = 2 ** (CntW - 1);

  // configuration
  logic [vfpt_pkg::TmoW-1:0]    timeout_q;
  logic [vfpt_pkg::TimeW-1:0]   base_q;
  logic [vfpt_pkg::IntvW-1:0]   pal_iv_q, ntsc_iv_q;
  logic [vfpt_pkg::HeightW-1:0] pal_hgt_q, ntsc_hgt_q;

  // frame state
  logic [vfpt_pkg::FrameW-1:0]  cur_q, cur_d;
  logic [vfpt_pkg::MsW-1:0]     start_q, start_d;
  logic [CntW-1:0]              rcv_q, rcv_d;
  logic [CntW-1:0]              exp_q, exp_d;
  logic [vfpt_pkg::FrameW-1:0]  ref_q, ref_d;
  logic [vfpt_pkg::FrameW-1:0]  dlvd_q, dlvd_d;
  logic [vfpt_pkg::HeightW-1:0] hgt_q, hgt_d;
  logic                         pal_q, pal_d;
  logic [EpochW-1:0]            epoch_q, epoch_d;

  // pipeline
  logic advance, accept;
  logic v1_q, v2_q, v3_q, vo_q;

  logic [IdxPW-1:0] idx_prod;
  logic [LineW-1:0] idx_full;

  logic [vfpt_pkg::FrameW-1:0] s1_frame_q;
  logic [LineW-1:0]            s1_line_q;
  logic                        s1_last_q;
  logic [vfpt_pkg::MsW-1:0]    s1_arr_q;
  logic                        s1_inr_q;
  logic [AddrW-1:0]            s1_addr_q;
  logic [CntW-1:0]             s1_idxc_q;

  vfpt_pkg::res_t res1, s2_res_q, s3_res_q, out_res_q;

  logic                        hit;
  logic                        wr_en;
  logic                        new_fr;
  logic                        dlv;
  logic                        neg;
  logic [vfpt_pkg::MagW-1:0]   mag;
  logic [vfpt_pkg::IntvW-1:0]  iv;

  assign advance    = !vo_q || out_ready_i;
  assign in_ready_o = advance;
  assign accept     = in_valid_i && advance;

  assign idx_prod = IdxPW'(start_line_i) * IdxPW'(Recip);
  assign idx_full = idx_prod[Shift +: LineW];

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q  <= vfpt_pkg::TimeoutRst;
      base_q     <= '0;
      pal_iv_q   <= vfpt_pkg::PalIntvRst;
      ntsc_iv_q  <= vfpt_pkg::NtscIntvRst;
      pal_hgt_q  <= vfpt_pkg::PalHgtRst;
      ntsc_hgt_q <= vfpt_pkg::NtscHgtRst;
    end else if (cfg_we_i) begin
      unique case (vfpt_pkg::cfg_reg_e'(cfg_idx_i))
        vfpt_pkg::REG_TIMEOUT:   timeout_q  <= cfg_wdata_i[vfpt_pkg::TmoW-1:0];
        vfpt_pkg::REG_BASE_TIME: base_q     <= cfg_wdata_i;
        vfpt_pkg::REG_PAL_INTV:  pal_iv_q   <= cfg_wdata_i[vfpt_pkg::IntvW-1:0];
        vfpt_pkg::REG_NTSC_INTV: ntsc_iv_q  <= cfg_wdata_i[vfpt_pkg::IntvW-1:0];
        vfpt_pkg::REG_PAL_HGT:   pal_hgt_q  <= cfg_wdata_i[vfpt_pkg::HeightW-1:0];
        vfpt_pkg::REG_NTSC_HGT:  ntsc_hgt_q <= cfg_wdata_i[vfpt_pkg::HeightW-1:0];
        default: ;
      endcase
    end
  end

  vfpt_map #(
    .MaxPackets(MaxPackets)
  ) u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (idx_full[AddrW-1:0]),
    .lk_addr_i (s1_addr_q),
    .epoch_i   (epoch_q),
    .hit_o     (hit),
    .wr_en_i   (wr_en),
    .wr_addr_i (s1_addr_q),
    .wr_tag_i  (epoch_d)
  );

  // stage 1: frame bookkeeping for one request
  always_comb begin
    logic                         complete;
    logic                         timed_out;
    logic [vfpt_pkg::MsW-1:0]     age;
    logic [CntW-1:0]              rcv_b, exp_b;
    logic [vfpt_pkg::HeightW-1:0] h;
    logic [vfpt_pkg::FrameW-1:0]  diff;

    cur_d   = cur_q;
    start_d = start_q;
    rcv_d   = rcv_q;
    exp_d   = exp_q;
    ref_d   = ref_q;
    dlvd_d  = dlvd_q;
    hgt_d   = hgt_q;
    pal_d   = pal_q;
    epoch_d = epoch_q;
    wr_en   = 1'b0;
    dlv     = 1'b0;
    neg     = 1'b0;
    mag     = '0;
    iv      = pal_q ? pal_iv_q : ntsc_iv_q;
    res1    = '0;

    new_fr    = s1_frame_q != cur_q;
    age       = s1_arr_q - start_q;
    timed_out = age > vfpt_pkg::MsW'(timeout_q);
    complete  = (exp_q != '0) && (rcv_q >= exp_q);
    diff      = '0;

    if (new_fr) begin
      if (rcv_q != '0) begin
        res1.ev_frame = cur_q;
        if (complete) begin
          if (dlvd_q != cur_q) begin
            dlv              = 1'b1;
            dlvd_d           = cur_q;
            res1.event_kind  = vfpt_pkg::EV_DELIVERED;
            if ((ref_q == '0) || (cur_q < ref_q)) begin
              ref_d = cur_q;
            end
            diff = cur_q - ref_d;
            neg  = diff > vfpt_pkg::HalfRange;
            mag  = neg ? (16'd0 - diff) : diff;
          end else begin
            res1.ev_frame = '0;
          end
        end else begin
          res1.event_kind = timed_out ? vfpt_pkg::EV_TIMED_OUT : vfpt_pkg::EV_ABANDONED;
        end
      end
      cur_d   = s1_frame_q;
      start_d = s1_arr_q;
      epoch_d = epoch_q + 1'b1;
    end

    rcv_b = new_fr ? '0 : rcv_q;
    exp_b = new_fr ? '0 : exp_q;
    rcv_d = rcv_b;
    exp_d = exp_b;

    if (!s1_inr_q) begin
      res1.status = vfpt_pkg::PKT_OUT_OF_RANGE;
    end else if (!new_fr && hit) begin
      res1.status = vfpt_pkg::PKT_DUPLICATE;
    end else begin
      res1.status = vfpt_pkg::PKT_ACCEPTED;
      wr_en       = advance && v1_q;
      rcv_d       = rcv_b + 1'b1;
    end

    h = {1'b0, s1_line_q} + vfpt_pkg::HeightW'(Lpp);
    if (s1_last_q && (exp_b == '0)) begin
      exp_d = s1_idxc_q + 1'b1;
      if ((hgt_q == '0) || (hgt_q != h)) begin
        hgt_d = h;
        if (h == pal_hgt_q) begin
          pal_d = 1'b1;
        end else if (h == ntsc_hgt_q) begin
          pal_d = 1'b0;
        end else begin
          pal_d = h > vfpt_pkg::UnknownSplit;
        end
      end
    end

    res1.height = hgt_d;
    res1.pal    = pal_d;
    res1.rcv    = rcv_d[CntW-1] ? '1 : rcv_d[vfpt_pkg::CountW-1:0];
    res1.expct  = exp_d[CntW-1] ? '1 : exp_d[vfpt_pkg::CountW-1:0];
  end

  vfpt_ts u_ts (
    .clk_i  (clk_i),
    .en_i   (advance),
    .dlv_i  (dlv),
    .neg_i  (neg),
    .mag_i  (mag),
    .iv_i   (iv),
    .base_i (base_q),
    .ts_o   (ideal_time_ns_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      vo_q    <= 1'b0;
      cur_q   <= '0;
      start_q <= '0;
      rcv_q   <= '0;
      exp_q   <= '0;
      ref_q   <= '0;
      dlvd_q  <= '0;
      hgt_q   <= '0;
      pal_q   <= 1'b1;
      epoch_q <= '0;
    end else if (advance) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vo_q <= v3_q;
      if (v1_q) begin
        cur_q   <= cur_d;
        start_q <= start_d;
        rcv_q   <= rcv_d;
        exp_q   <= exp_d;
        ref_q   <= ref_d;
        dlvd_q  <= dlvd_d;
        hgt_q   <= hgt_d;
        pal_q   <= pal_d;
        epoch_q <= epoch_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_frame_q <= frame_number_i;
      s1_line_q  <= start_line_i;
      s1_last_q  <= is_last_i;
      s1_arr_q   <= arrival_ms_i;
      s1_inr_q   <= idx_full < LineW'(MaxPackets);
      s1_addr_q  <= idx_full[AddrW-1:0];
      s1_idxc_q  <= (idx_full >= LineW'(ExpCap)) ? CntW'(ExpCap) : idx_full[CntW-1:0];
      s2_res_q   <= res1;
      s3_res_q   <= s2_res_q;
      out_res_q  <= s3_res_q;
    end
  end

  assign out_valid_o      = vo_q;
  assign packet_status_o  = out_res_q.status;
  assign frame_event_o    = out_res_q.event_kind;
  assign event_frame_o    = out_res_q.ev_frame;
  assign height_lines_o   = out_res_q.height;
  assign is_pal_o         = out_res_q.pal;
  assign received_count_o = out_res_q.rcv;
  assign expected_count_o = out_res_q.expct;

endmodule

[src/vfpt_map.sv]
// Received-packet map: epoch tag memory, per-entry valid flops and a
// background scrubber that retires stale tags. Depends on vfpt_pkg for the MaxPackets default.
module vfpt_map #(
  parameter int MaxPackets = vfpt_pkg::MaxPacketsDef,
  localparam int AddrW  = $clog2(MaxPackets),
  localparam int EpochW = AddrW + 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [AddrW-1:0]  rd_addr_i,
  input  logic [AddrW-1:0]  lk_addr_i,
  input  logic [EpochW-1:0] epoch_i,
  output logic              hit_o,
  input  logic              wr_en_i,
  input  logic [AddrW-1:0]  wr_addr_i,
  input  logic [EpochW-1:0] wr_tag_i
);

  logic [EpochW-1:0]     tag_mem [MaxPackets];
  logic [EpochW-1:0]     rd_tag_q;
  logic [MaxPackets-1:0] valid_q, valid_d;

  // last write ever made; covers a read issued on the same edge as that write
  logic              fwd_vld_q;
  logic [AddrW-1:0]  fwd_addr_q;
  logic [EpochW-1:0] fwd_tag_q;

  // write on the previous edge, for the scrubber
  logic              wr_prev_q;
  logic [AddrW-1:0]  wr_prev_addr_q;

  logic [AddrW-1:0]  scr_ptr_q;
  logic [AddrW-1:0]  scr_addr_q;
  logic [EpochW-1:0] scr_tag_q;
  logic              scr_clr;
  logic [EpochW-1:0] lk_tag;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      tag_mem[wr_addr_i] <= wr_tag_i;
    end
    if (rd_en_i) begin
      rd_tag_q <= tag_mem[rd_addr_i];
    end
    scr_tag_q  <= tag_mem[scr_ptr_q];
    scr_addr_q <= scr_ptr_q;
    if (wr_en_i) begin
      fwd_addr_q <= wr_addr_i;
      fwd_tag_q  <= wr_tag_i;
    end
    wr_prev_addr_q <= wr_addr_i;
  end

  always_comb begin
    valid_d = valid_q;
    if (scr_clr) begin
      valid_d[scr_addr_q] = 1'b0;
    end
    if (wr_en_i) begin
      valid_d[wr_addr_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
      wr_prev_q <= 1'b0;
      scr_ptr_q <= '0;
      valid_q   <= '0;
    end else begin
      fwd_vld_q <= fwd_vld_q | wr_en_i;
      wr_prev_q <= wr_en_i;
      scr_ptr_q <= (scr_ptr_q == AddrW'(MaxPackets - 1)) ? '0 : scr_ptr_q + 1'b1;
      valid_q   <= valid_d;
    end
  end

  // An entry whose tag is behind the epoch is retired before the epoch can
  // wrap back onto it. Skip when the entry is being rewritten around the read.
  assign scr_clr = (scr_tag_q != epoch_i)
                 && !(wr_prev_q && (wr_prev_addr_q == scr_addr_q))
                 && !(wr_en_i && (wr_addr_i == scr_addr_q));

  assign lk_tag = (fwd_vld_q && (fwd_addr_q == lk_addr_i)) ? fwd_tag_q : rd_tag_q;
  assign hit_o  = valid_q[lk_addr_i] && (lk_tag == epoch_i);

endmodule

[src/vfpt_ts.sv]
// Ideal timestamp pipeline: operand register, offset-times-interval multiply,
// then signed add to the base time (zero when no frame is delivered). Depends on vfpt_pkg.
module vfpt_ts (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic                          dlv_i,
  input  logic                          neg_i,
  input  logic [vfpt_pkg::MagW-1:0]     mag_i,
  input  logic [vfpt_pkg::IntvW-1:0]    iv_i,
  input  logic [vfpt_pkg::TimeW-1:0]    base_i,
  output logic [vfpt_pkg::TimeW-1:0]    ts_o
);

  logic                          dlv2_q, neg2_q, dlv3_q, neg3_q;
  logic [vfpt_pkg::MagW-1:0]     mag2_q;
  logic [vfpt_pkg::IntvW-1:0]    iv2_q;
  logic [vfpt_pkg::ProdW-1:0]    prod3_q;
  logic [vfpt_pkg::TimeW-1:0]    prod_ext;
  logic [vfpt_pkg::TimeW-1:0]    ts_d;
  logic [vfpt_pkg::TimeW-1:0]    ts_q;

  assign prod_ext = vfpt_pkg::TimeW'(prod3_q);

  always_comb begin
    if (!dlv3_q) begin
      ts_d = '0;
    end else if (neg3_q) begin
      ts_d = base_i - prod_ext;
    end else begin
      ts_d = base_i + prod_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dlv2_q  <= dlv_i;
      neg2_q  <= neg_i;
      mag2_q  <= mag_i;
      iv2_q   <= iv_i;
      dlv3_q  <= dlv2_q;
      neg3_q  <= neg2_q;
      prod3_q <= vfpt_pkg::ProdW'(mag2_q) * vfpt_pkg::ProdW'(iv2_q);
      ts_q    <= ts_d;
    end
  end

  assign ts_o = ts_q;

endmodule
